// File: rtl/plm_pkg.sv
// Shared types, widths and codes of the packet loss and delay monitor.
`default_nettype none

package plm_pkg;

   localparam int SEQ_W   = 31;
   localparam int BYTES_W = 16;
   localparam int TIME_W  = 48;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int SIZE_W  = 48;
   localparam int EXP_W   = 32;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 184;
   localparam int DIV_CNT_W  = 6;

   localparam logic FUNC_ARRIVAL = 1'b0;
   localparam logic FUNC_CLEAR   = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DELTA,
      S_ACCUM,
      S_DIV_GO,
      S_DIV_WAIT,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_DELAY,
      SEL_SIZE,
      SEL_GAP
   } sel_type;

   typedef struct packed {
      logic    ready;
      logic    take;
      logic    delta;
      logic    accum;
      logic    div_start;
      sel_type div_sel;
      logic    quot_load;
      logic    rsp_load;
   } seq_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

// File: rtl/plm_divider.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none

module plm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [plm_pkg::SUM_W-1:0]     dividend,
   input  wire logic [plm_pkg::CNT_W-1:0]     divisor,
   output plm_pkg::div_stat_type              stat,
   output logic      [plm_pkg::SUM_W-1:0]     quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [plm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [plm_pkg::SUM_W-1:0]         quot_ff, quot_in;
   logic [plm_pkg::CNT_W-1:0]         rem_ff, rem_in;
   logic [plm_pkg::CNT_W-1:0]         dsr_ff, dsr_in;
   logic [plm_pkg::CNT_W:0]           shifted;
   logic [plm_pkg::CNT_W+1:0]         diff;

   always_comb begin
      shifted = {rem_ff, quot_ff[plm_pkg::SUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         quot_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (diff[plm_pkg::CNT_W+1]) begin
            rem_in  = shifted[plm_pkg::CNT_W-1:0];
            quot_in = {quot_ff[plm_pkg::SUM_W-2:0], 1'b0};
         end else begin
            rem_in  = diff[plm_pkg::CNT_W-1:0];
            quot_in = {quot_ff[plm_pkg::SUM_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quot_ff;

endmodule

`default_nettype wire

// File: rtl/plm_stats.sv
// Running counts, saturating sums and sequence gap tracking.
`default_nettype none

module plm_stats (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire plm_pkg::seq_ctrl_type           ctrl,
   input  wire logic                            func,
   input  wire logic [plm_pkg::SEQ_W-1:0]       seq_number,
   input  wire logic [plm_pkg::BYTES_W-1:0]     pkt_bytes,
   input  wire logic [plm_pkg::TIME_W-1:0]      send_time,
   input  wire logic [plm_pkg::TIME_W-1:0]      arrive_time,
   output logic      [plm_pkg::CNT_W-1:0]       pkt_count,
   output logic      [plm_pkg::CNT_W-1:0]       lost_count,
   output logic      [plm_pkg::SIZE_W-1:0]      size_sum,
   output logic      [plm_pkg::SUM_W-1:0]       delay_sum,
   output logic      [plm_pkg::SUM_W-1:0]       gap_sum,
   output logic                                 loss_seen
);

   logic                              func_ff;
   logic [plm_pkg::SEQ_W-1:0]         seq_ff;
   logic [plm_pkg::BYTES_W-1:0]       bytes_ff;
   logic [plm_pkg::TIME_W-1:0]        send_ff;
   logic [plm_pkg::TIME_W-1:0]        arrive_ff;

   logic [plm_pkg::TIME_W-1:0]        delay_d_ff, delay_d_in;
   logic [plm_pkg::TIME_W-1:0]        gap_d_ff, gap_d_in;
   logic [plm_pkg::SEQ_W-1:0]         lost_d_ff, lost_d_in;
   logic                              gap_hit_ff, gap_hit_in;

   logic [plm_pkg::EXP_W-1:0]         expected_ff, expected_in;
   logic                              known_ff, known_in;
   logic [plm_pkg::TIME_W-1:0]        last_ff, last_in;
   logic [plm_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [plm_pkg::CNT_W-1:0]         lost_ff, lost_in;
   logic [plm_pkg::SIZE_W-1:0]        size_ff, size_in;
   logic [plm_pkg::SUM_W-1:0]         delay_ff, delay_in;
   logic [plm_pkg::SUM_W-1:0]         gapsum_ff, gapsum_in;
   logic                              seen_ff, seen_in;

   logic [plm_pkg::EXP_W:0]           seq_diff;
   logic [plm_pkg::CNT_W:0]           count_add;
   logic [plm_pkg::CNT_W:0]           lost_add;
   logic [plm_pkg::SIZE_W:0]          size_add;
   logic [plm_pkg::SUM_W:0]           delay_add;
   logic [plm_pkg::SUM_W:0]           gap_add;

   always_comb begin
      delay_d_in = delay_d_ff;
      gap_d_in   = gap_d_ff;
      lost_d_in  = lost_d_ff;
      gap_hit_in = gap_hit_ff;
      seq_diff   = {2'b00, seq_ff} - {1'b0, expected_ff};
      if (ctrl.delta) begin
         delay_d_in = (arrive_ff >= send_ff) ? arrive_ff - send_ff : '0;
         gap_d_in   = (arrive_ff >= last_ff) ? arrive_ff - last_ff : '0;
         lost_d_in  = seq_diff[plm_pkg::SEQ_W-1:0];
         gap_hit_in = known_ff && !seq_diff[plm_pkg::EXP_W] && (seq_diff != '0);
      end
   end

   always_comb begin
      count_add = {1'b0, count_ff} + {{plm_pkg::CNT_W{1'b0}}, 1'b1};
      lost_add  = {1'b0, lost_ff} + {2'b00, lost_d_ff};
      size_add  = {1'b0, size_ff} + {{(plm_pkg::SIZE_W-plm_pkg::BYTES_W+1){1'b0}}, bytes_ff};
      delay_add = {1'b0, delay_ff}
                + {{(plm_pkg::SUM_W-plm_pkg::TIME_W+1){1'b0}}, delay_d_ff};
      gap_add   = {1'b0, gapsum_ff}
                + {{(plm_pkg::SUM_W-plm_pkg::TIME_W+1){1'b0}}, gap_d_ff};
      expected_in = expected_ff;
      known_in    = known_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      lost_in     = lost_ff;
      size_in     = size_ff;
      delay_in    = delay_ff;
      gapsum_in   = gapsum_ff;
      seen_in     = seen_ff;
      if (ctrl.accum) begin
         if (func_ff == plm_pkg::FUNC_CLEAR) begin
            known_in = 1'b0;
            seen_in  = 1'b0;
         end else begin
            count_in  = count_add[plm_pkg::CNT_W] ? '1 : count_add[plm_pkg::CNT_W-1:0];
            size_in   = size_add[plm_pkg::SIZE_W] ? '1 : size_add[plm_pkg::SIZE_W-1:0];
            delay_in  = delay_add[plm_pkg::SUM_W] ? '1 : delay_add[plm_pkg::SUM_W-1:0];
            gapsum_in = gap_add[plm_pkg::SUM_W] ? '1 : gap_add[plm_pkg::SUM_W-1:0];
            if (gap_hit_ff) begin
               lost_in = lost_add[plm_pkg::CNT_W] ? '1 : lost_add[plm_pkg::CNT_W-1:0];
            end
            seen_in     = gap_hit_ff;
            last_in     = arrive_ff;
            expected_in = {1'b0, seq_ff} + {{(plm_pkg::EXP_W-1){1'b0}}, 1'b1};
            known_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         func_ff   <= func;
         seq_ff    <= seq_number;
         bytes_ff  <= pkt_bytes;
         send_ff   <= send_time;
         arrive_ff <= arrive_time;
      end
      delay_d_ff <= delay_d_in;
      gap_d_ff   <= gap_d_in;
      lost_d_ff  <= lost_d_in;
      gap_hit_ff <= gap_hit_in;
      if (reset) begin
         expected_ff <= '0;
         known_ff    <= 1'b0;
         last_ff     <= '0;
         count_ff    <= '0;
         lost_ff     <= '0;
         size_ff     <= '0;
         delay_ff    <= '0;
         gapsum_ff   <= '0;
         seen_ff     <= 1'b0;
      end else begin
         expected_ff <= expected_in;
         known_ff    <= known_in;
         last_ff     <= last_in;
         count_ff    <= count_in;
         lost_ff     <= lost_in;
         size_ff     <= size_in;
         delay_ff    <= delay_in;
         gapsum_ff   <= gapsum_in;
         seen_ff     <= seen_in;
      end
   end

   assign pkt_count  = count_ff;
   assign lost_count = lost_ff;
   assign size_sum   = size_ff;
   assign delay_sum  = delay_ff;
   assign gap_sum    = gapsum_ff;
   assign loss_seen  = seen_ff;

endmodule

`default_nettype wire

// File: rtl/plm_seq.sv
// Sequencer: update the statistics, then run three divisions on the shared divider.
`default_nettype none

module plm_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    rsp_full,
   input  wire logic                    rsp_tready,
   input  wire plm_pkg::div_stat_type   div_stat,
   output plm_pkg::seq_ctrl_type        ctrl
);

   plm_pkg::state_type state_ff, state_in;
   plm_pkg::sel_type   sel_ff, sel_in;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         plm_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = plm_pkg::S_DELTA;
            end
         end
         plm_pkg::S_DELTA: begin
            state_in = plm_pkg::S_ACCUM;
         end
         plm_pkg::S_ACCUM: begin
            state_in = plm_pkg::S_DIV_GO;
            sel_in   = plm_pkg::SEL_DELAY;
         end
         plm_pkg::S_DIV_GO: begin
            state_in = plm_pkg::S_DIV_WAIT;
         end
         plm_pkg::S_DIV_WAIT: begin
            if (div_stat.done) begin
               case (sel_ff)
                  plm_pkg::SEL_DELAY: begin
                     sel_in   = plm_pkg::SEL_SIZE;
                     state_in = plm_pkg::S_DIV_GO;
                  end
                  plm_pkg::SEL_SIZE: begin
                     sel_in   = plm_pkg::SEL_GAP;
                     state_in = plm_pkg::S_DIV_GO;
                  end
                  default: begin
                     state_in = plm_pkg::S_OUT;
                  end
               endcase
            end
         end
         plm_pkg::S_OUT: begin
            if (!rsp_full || rsp_tready) begin
               state_in = plm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plm_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl           = '0;
      ctrl.div_sel   = sel_ff;
      case (state_ff)
         plm_pkg::S_IDLE: begin
            ctrl.ready = 1'b1;
            ctrl.take  = req_tvalid;
         end
         plm_pkg::S_DELTA: begin
            ctrl.delta = 1'b1;
         end
         plm_pkg::S_ACCUM: begin
            ctrl.accum = 1'b1;
         end
         plm_pkg::S_DIV_GO: begin
            ctrl.div_start = 1'b1;
         end
         plm_pkg::S_DIV_WAIT: begin
            ctrl.quot_load = div_stat.done;
         end
         plm_pkg::S_OUT: begin
            ctrl.rsp_load = !rsp_full || rsp_tready;
         end
         default: begin
            ctrl.ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plm_pkg::S_IDLE;
         sel_ff   <= plm_pkg::SEL_DELAY;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/packet_loss_delay_monitor_top.sv
// Top level of the packet loss and delay monitor.
`default_nettype none

// Each request transfer is either a packet arrival (tuser 0) or a clear of the
// expected sequence number (tuser 1), and yields exactly one response transfer
// carrying the lost and packet totals, the loss flag of this packet and the
// floor means of delay, size and inter-arrival gap over the packet count.
// Per item, the sequencer takes the request, updates the sums in the delta and
// accumulate states, runs three 64-bit by 32-bit divisions one after another on
// a single radix-2 divider, and loads the response. The request side is ready
// only between items; a finished response waits in the output register while
// the next request is taken, and a response still waiting when the next one is
// ready holds the sequencer until it is taken.

module packet_loss_delay_monitor_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // seq_number[30:0], pkt_bytes[46:31], send_time[94:47], arrive_time[142:95], zero
   input  wire logic [plm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // lost_total[31:0], packet_total[63:32], loss_seen[64], avg_delay[112:65],
   // avg_size[128:113], avg_gap[176:129], zero
   output logic      [plm_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   plm_pkg::seq_ctrl_type ctrl;
   plm_pkg::div_stat_type div_stat;

   logic [plm_pkg::CNT_W-1:0]    pkt_count;
   logic [plm_pkg::CNT_W-1:0]    lost_count;
   logic [plm_pkg::SIZE_W-1:0]   size_sum;
   logic [plm_pkg::SUM_W-1:0]    delay_sum;
   logic [plm_pkg::SUM_W-1:0]    gap_sum;
   logic                         loss_seen;
   logic [plm_pkg::SUM_W-1:0]    dividend;
   logic [plm_pkg::SUM_W-1:0]    quotient;

   logic [plm_pkg::TIME_W-1:0]   avg_delay_ff, avg_gap_ff;
   logic [plm_pkg::BYTES_W-1:0]  avg_size_ff;
   logic [plm_pkg::TIME_W-1:0]   q_time;
   logic [plm_pkg::BYTES_W-1:0]  q_size;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [plm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   plm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_full   (rsp_valid_ff),
      .rsp_tready (rsp_tready),
      .div_stat   (div_stat),
      .ctrl       (ctrl)
   );

   plm_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .func        (req_tuser),
      .seq_number  (req_tdata[30:0]),
      .pkt_bytes   (req_tdata[46:31]),
      .send_time   (req_tdata[94:47]),
      .arrive_time (req_tdata[142:95]),
      .pkt_count   (pkt_count),
      .lost_count  (lost_count),
      .size_sum    (size_sum),
      .delay_sum   (delay_sum),
      .gap_sum     (gap_sum),
      .loss_seen   (loss_seen)
   );

   always_comb begin
      case (ctrl.div_sel)
         plm_pkg::SEL_DELAY: dividend = delay_sum;
         plm_pkg::SEL_SIZE:  dividend = {{(plm_pkg::SUM_W-plm_pkg::SIZE_W){1'b0}}, size_sum};
         plm_pkg::SEL_GAP:   dividend = gap_sum;
         default:            dividend = '0;
      endcase
   end

   plm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (dividend),
      .divisor  (pkt_count),
      .stat     (div_stat),
      .quotient (quotient)
   );

   always_comb begin
      if (pkt_count == '0) begin
         q_time = '0;
         q_size = '0;
      end else begin
         q_time = (|quotient[plm_pkg::SUM_W-1:plm_pkg::TIME_W]) ? '1
                : quotient[plm_pkg::TIME_W-1:0];
         q_size = (|quotient[plm_pkg::SUM_W-1:plm_pkg::BYTES_W]) ? '1
                : quotient[plm_pkg::BYTES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.quot_load) begin
         case (ctrl.div_sel)
            plm_pkg::SEL_DELAY: avg_delay_ff <= q_time;
            plm_pkg::SEL_SIZE:  avg_size_ff  <= q_size;
            default:            avg_gap_ff   <= q_time;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (ctrl.rsp_load) begin
         rsp_data_ff <= {7'b0, avg_gap_ff, avg_size_ff, avg_delay_ff, loss_seen,
                         pkt_count, lost_count};
      end
   end

   assign req_tready = ctrl.ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("divider busy while taking a request");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> !req_tready)
      else $error("division finished outside an item");

   a_load_space: assert property (@(posedge clock) disable iff (reset)
      ctrl.rsp_load |-> (!rsp_valid_ff || rsp_tready) && !req_tready)
      else $error("response loaded over a pending transfer");

endmodule

`default_nettype wire
